>>> sv/nntt_pkg.sv
// Package for the nearest-neighbour track table.
// Holds shared types, codes and constants; no dependencies.
package nntt_pkg;

	localparam int CoordW = 20;
	localparam int VelW = 24;
	localparam int TimeW = 32;
	localparam int IdW = 32;
	localparam int CntW = 6;
	localparam int CfgW = 16;
	localparam int DistW = 43;
	localparam int DiffW = 21;
	localparam int NumW = 31;
	localparam int QuotW = 31;
	localparam logic signed [VelW-1:0] VelMax = 24'sd8388607;
	localparam logic signed [VelW-1:0] VelMin = -24'sd8388608;

	typedef enum logic [1:0] {
		OUT_UPDATED = 2'd0,
		OUT_CREATED = 2'd1,
		OUT_DROPPED = 2'd2,
		OUT_SWEPT   = 2'd3
	} outcome_t;

	typedef enum logic {
		REG_MATCH_DIST = 1'b0,
		REG_EXPIRY     = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_DECIDE,
		ST_DIV,
		ST_DIV_WAIT,
		ST_WRITE,
		ST_SWEEP,
		ST_SWEEP_WAIT,
		ST_SWEEP_CLR,
		ST_OUT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load_item;
		logic scan_rd;
		logic scan_eval;
		logic div_start;
		logic div_axis_next;
		logic write_match;
		logic write_new;
		logic sweep_rd;
		logic sweep_eval;
		logic sweep_clr;
		logic set_out;
		logic [1:0] outcome;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic action;
		logic found;
		logic full;
		logic dt_zero;
		logic div_done;
		logic div_last_axis;
		logic scan_last;
		logic sweep_last;
		logic clr_last;
	} sts_t;

endpackage

>>> sv/nntt_if.sv
// Valid/ready channel interfaces for the track table.
// Depends on nntt_pkg for field widths.
interface nntt_in_if;
	import nntt_pkg::*;
	logic valid;
	logic ready;
	logic action;
	logic [TimeW-1:0] time_ms;
	logic signed [CoordW-1:0] centroid_x;
	logic signed [CoordW-1:0] centroid_y;
	logic signed [CoordW-1:0] centroid_z;
	modport source (output valid, action, time_ms, centroid_x, centroid_y, centroid_z,
		input ready);
	modport sink (input valid, action, time_ms, centroid_x, centroid_y, centroid_z,
		output ready);
endinterface

interface nntt_out_if;
	import nntt_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] outcome;
	logic [IdW-1:0] track_id;
	logic signed [VelW-1:0] vel_x;
	logic signed [VelW-1:0] vel_y;
	logic signed [VelW-1:0] vel_z;
	logic [CntW-1:0] removed_count;
	logic [CntW-1:0] live_count;
	modport source (output valid, outcome, track_id, vel_x, vel_y, vel_z, removed_count,
		live_count, input ready);
	modport sink (input valid, outcome, track_id, vel_x, vel_y, vel_z, removed_count,
		live_count, output ready);
endinterface

interface nntt_cfg_if;
	import nntt_pkg::*;
	logic valid;
	logic ready;
	logic [0:0] index;
	logic [CfgW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/nntt_div.sv
// Restoring serial divider: unsigned numerator by 32-bit divisor, one bit a cycle.
// Depends on nntt_pkg for widths.
module nntt_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [nntt_pkg::NumW-1:0] num,
	input  logic [nntt_pkg::TimeW-1:0] den,
	output logic done,
	output logic [nntt_pkg::QuotW-1:0] quot
);
	import nntt_pkg::*;

	logic [TimeW:0] rem_q;
	logic [NumW-1:0] sh_q;
	logic [TimeW-1:0] den_q;
	logic [$clog2(NumW+1)-1:0] cnt_q;
	logic busy_q;
	logic [TimeW:0] trial;

	assign trial = {rem_q[TimeW-1:0], sh_q[NumW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(NumW+1))'(NumW-1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			sh_q <= {sh_q[NumW-2:0], ~trial[TimeW]};
			if (!trial[TimeW])
				rem_q <= trial;
			else
				rem_q <= {rem_q[TimeW-1:0], sh_q[NumW-1]};
		end
	end

	assign quot = sh_q;
endmodule

>>> sv/nntt_datapath.sv
// Datapath of the track table: slot memories, distance scan, velocity and sweep.
// Depends on nntt_pkg and nntt_div.
module nntt_datapath #(
	parameter int MAX_TRACKS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  nntt_pkg::cmd_t cmd,
	output nntt_pkg::sts_t sts,
	input  logic in_action,
	input  logic [nntt_pkg::TimeW-1:0] in_time,
	input  logic signed [nntt_pkg::CoordW-1:0] in_cx,
	input  logic signed [nntt_pkg::CoordW-1:0] in_cy,
	input  logic signed [nntt_pkg::CoordW-1:0] in_cz,
	input  logic [nntt_pkg::CfgW-1:0] match_dist,
	input  logic [nntt_pkg::CfgW-1:0] expiry,
	output logic [1:0] o_outcome,
	output logic [nntt_pkg::IdW-1:0] o_id,
	output logic signed [nntt_pkg::VelW-1:0] o_vx,
	output logic signed [nntt_pkg::VelW-1:0] o_vy,
	output logic signed [nntt_pkg::VelW-1:0] o_vz,
	output logic [nntt_pkg::CntW-1:0] o_removed,
	output logic [nntt_pkg::CntW-1:0] o_live
);
	import nntt_pkg::*;

	localparam int IdxW = $clog2(MAX_TRACKS);
	localparam int LiveW = $clog2(MAX_TRACKS + 1);
	localparam int EntW = IdW + 3*CoordW + 3*VelW + TimeW;

	// One wide entry memory; validity is a live prefix count.
	logic [EntW-1:0] mem [MAX_TRACKS];
	logic [EntW-1:0] rd_q;
	logic [IdxW-1:0] rd_addr;
	logic mem_we;
	logic [IdxW-1:0] wr_addr;
	logic [EntW-1:0] wr_data;

	logic [LiveW-1:0] live_q;
	logic [IdW-1:0] next_id_q;
	logic action_q;
	logic [TimeW-1:0] now_q;
	logic signed [CoordW-1:0] c_q [3];
	logic [LiveW-1:0] ptr_q;     // read pointer
	logic [LiveW-1:0] eval_q;    // index of the entry in rd_q
	logic [LiveW-1:0] wptr_q;    // sweep write pointer
	logic [LiveW-1:0] removed_q;
	logic [DistW-1:0] best_q;
	logic found_q;
	logic [IdxW-1:0] best_idx_q;
	logic [EntW-1:0] best_ent_q;
	logic [1:0] axis_q;
	logic signed [VelW-1:0] vel_q [3];
	logic [1:0] outcome_q;
	logic [IdW-1:0] oid_q;
	logic signed [VelW-1:0] ovel_q [3];
	logic [CntW-1:0] orem_q;
	logic [CntW-1:0] olive_q;

	// Entry fields from the read register.
	logic signed [CoordW-1:0] e_pos [3];
	logic [TimeW-1:0] e_seen;
	assign e_pos[0] = rd_q[EntW-IdW-1 -: CoordW];
	assign e_pos[1] = rd_q[EntW-IdW-CoordW-1 -: CoordW];
	assign e_pos[2] = rd_q[EntW-IdW-2*CoordW-1 -: CoordW];
	assign e_seen = rd_q[TimeW-1:0];

	logic signed [DiffW-1:0] d [3];
	logic signed [2*DiffW-1:0] sq [3];
	logic [DistW-1:0] d2;
	logic [TimeW-1:0] age;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d[k] = DiffW'(c_q[k]) - DiffW'(e_pos[k]);
			sq[k] = d[k] * d[k];
		end
		// Each square is below 2^40, so its top bit is always clear.
		d2 = DistW'(sq[0][2*DiffW-2:0]) + DistW'(sq[1][2*DiffW-2:0])
			+ DistW'(sq[2][2*DiffW-2:0]);
		age = now_q - e_seen;
	end

	// Best-match entry fields.
	logic [IdW-1:0] b_id;
	logic signed [CoordW-1:0] b_pos [3];
	logic signed [VelW-1:0] b_vel [3];
	logic [TimeW-1:0] b_seen, dt;
	assign b_id = best_ent_q[EntW-1 -: IdW];
	assign b_pos[0] = best_ent_q[EntW-IdW-1 -: CoordW];
	assign b_pos[1] = best_ent_q[EntW-IdW-CoordW-1 -: CoordW];
	assign b_pos[2] = best_ent_q[EntW-IdW-2*CoordW-1 -: CoordW];
	assign b_vel[0] = best_ent_q[TimeW+3*VelW-1 -: VelW];
	assign b_vel[1] = best_ent_q[TimeW+2*VelW-1 -: VelW];
	assign b_vel[2] = best_ent_q[TimeW+VelW-1 -: VelW];
	assign b_seen = best_ent_q[TimeW-1:0];
	assign dt = now_q - b_seen;

	// Velocity written back on a match: unchanged when no time has passed.
	logic signed [VelW-1:0] wvel [3];
	always_comb begin
		for (int k = 0; k < 3; k++)
			wvel[k] = (dt == '0) ? b_vel[k] : vel_q[k];
	end

	// Divider on magnitude of (diff * 1000); sign restored afterwards.
	logic signed [DiffW-1:0] ddiff;
	logic neg;
	logic [DiffW-1:0] mag;
	logic [NumW-1:0] num;
	logic div_done;
	logic [QuotW-1:0] quot;
	logic signed [VelW-1:0] vsat;
	always_comb begin
		ddiff = DiffW'(c_q[axis_q]) - DiffW'(b_pos[axis_q]);
		neg = ddiff[DiffW-1];
		mag = neg ? DiffW'(-ddiff) : ddiff;
		num = NumW'(mag) * NumW'(10'd1000);
		if (quot > QuotW'(VelMax))
			vsat = neg ? VelMin : VelMax;
		else
			vsat = neg ? VelW'(-$signed({1'b0, quot[VelW-1:0]})) : VelW'(quot);
	end

	nntt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(num), .den(dt),
		.done(div_done), .quot(quot)
	);

	logic [2*CfgW-1:0] limit_sq;
	logic [DistW-1:0] limit;
	assign limit_sq = match_dist * match_dist;
	assign limit = DistW'(limit_sq);

	always_comb begin
		mem_we = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_addr = ptr_q[IdxW-1:0];
		if (cmd.write_match) begin
			mem_we = 1'b1;
			wr_addr = best_idx_q;
			wr_data = {b_id, c_q[0], c_q[1], c_q[2], wvel[0], wvel[1], wvel[2], now_q};
		end else if (cmd.write_new) begin
			mem_we = 1'b1;
			wr_addr = live_q[IdxW-1:0];
			wr_data = {next_id_q, c_q[0], c_q[1], c_q[2], {3*VelW{1'b0}}, now_q};
		end else if (cmd.sweep_eval && !(age > TimeW'(expiry))) begin
			mem_we = (wptr_q != eval_q);
			wr_addr = wptr_q[IdxW-1:0];
			wr_data = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			next_id_q <= '0;
		end else begin
			if (cmd.write_new) begin
				live_q <= live_q + 1'b1;
				next_id_q <= next_id_q + 1'b1;
			end
			if (cmd.sweep_clr)
				live_q <= wptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= in_action;
			now_q <= in_time;
			c_q[0] <= in_cx;
			c_q[1] <= in_cy;
			c_q[2] <= in_cz;
			ptr_q <= '0;
			wptr_q <= '0;
			removed_q <= '0;
			found_q <= 1'b0;
			best_q <= limit;
			axis_q <= '0;
		end
		if (cmd.scan_rd || cmd.sweep_rd) begin
			eval_q <= ptr_q;
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.scan_eval && d2 < best_q) begin
			best_q <= d2;
			found_q <= 1'b1;
			best_idx_q <= eval_q[IdxW-1:0];
			best_ent_q <= rd_q;
		end
		if (cmd.sweep_eval) begin
			if (age > TimeW'(expiry))
				removed_q <= removed_q + 1'b1;
			else
				wptr_q <= wptr_q + 1'b1;
		end
		if (cmd.div_start && axis_q == 2'd0) begin
			vel_q <= b_vel;
		end
		if (div_done)
			vel_q[axis_q] <= vsat;
		if (cmd.div_axis_next)
			axis_q <= axis_q + 1'b1;
		if (cmd.set_out) begin
			outcome_q <= cmd.outcome;
			orem_q <= CntW'(removed_q);
			olive_q <= CntW'(live_q);
			if (cmd.outcome == OUT_UPDATED) begin
				oid_q <= b_id;
				ovel_q <= wvel;
			end else begin
				oid_q <= (cmd.outcome == OUT_CREATED) ? next_id_q - 1'b1 : '0;
				ovel_q <= '{default: '0};
			end
		end
	end

	assign sts.action = action_q;
	assign sts.found = found_q;
	assign sts.full = (live_q == LiveW'(MAX_TRACKS));
	assign sts.dt_zero = (dt == '0);
	assign sts.div_done = div_done;
	assign sts.div_last_axis = (axis_q == 2'd2);
	assign sts.scan_last = (ptr_q >= live_q);
	assign sts.sweep_last = (ptr_q >= live_q);
	assign sts.clr_last = 1'b1;

	assign o_outcome = outcome_q;
	assign o_id = oid_q;
	assign o_vx = ovel_q[0];
	assign o_vy = ovel_q[1];
	assign o_vz = ovel_q[2];
	assign o_removed = orem_q;
	assign o_live = olive_q;
endmodule

>>> sv/nntt_ctrl.sv
// Controller state machine of the track table.
// Depends on nntt_pkg for state, command and status types.
module nntt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output nntt_pkg::cmd_t cmd,
	input  nntt_pkg::sts_t sts
);
	import nntt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load_item = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// Read-then-evaluate: each slot is read here and evaluated in ST_SCAN_WAIT.
				if (sts.action) begin
					state_d = ST_SWEEP;
				end else if (sts.scan_last) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d = ST_SCAN_WAIT;
				end
			end
			ST_SCAN_WAIT: begin
				cmd.scan_eval = 1'b1;
				state_d = ST_SCAN;
			end
			ST_DECIDE: begin
				if (sts.found) begin
					state_d = sts.dt_zero ? ST_WRITE : ST_DIV;
				end else if (sts.full) begin
					cmd.set_out = 1'b1;
					cmd.outcome = OUT_DROPPED;
					state_d = ST_OUT;
				end else begin
					cmd.write_new = 1'b1;
					state_d = ST_WRITE;
				end
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					if (sts.div_last_axis) begin
						state_d = ST_WRITE;
					end else begin
						cmd.div_axis_next = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_WRITE: begin
				cmd.set_out = 1'b1;
				if (sts.found) begin
					cmd.write_match = 1'b1;
					cmd.outcome = OUT_UPDATED;
				end else begin
					cmd.outcome = OUT_CREATED;
				end
				state_d = ST_OUT;
			end
			ST_SWEEP: begin
				if (sts.sweep_last) begin
					cmd.sweep_clr = 1'b1;
					state_d = ST_SWEEP_CLR;
				end else begin
					cmd.sweep_rd = 1'b1;
					state_d = ST_SWEEP_WAIT;
				end
			end
			ST_SWEEP_WAIT: begin
				cmd.sweep_eval = 1'b1;
				state_d = ST_SWEEP;
			end
			ST_SWEEP_CLR: begin
				cmd.set_out = 1'b1;
				cmd.outcome = OUT_SWEPT;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> sv/nearest_neighbour_track_table.sv
// Nearest-neighbour track table, top level.
// Processing: a scan or sweep over the live slots, then, for a match with
// time elapsed, three serial velocity divisions, one per axis.
// Throughput: one item at a time; the slot memory read port and divider set it.
// Reset: arst_n clears the table (live count), the id counter and the
// registers to 200 and 1000; no clearing pass is needed.
module nearest_neighbour_track_table #(
	parameter int MAX_TRACKS = 32
) (
	input  logic clk,
	input  logic arst_n,
	nntt_in_if.sink in,
	nntt_out_if.source out,
	nntt_cfg_if.sink cfg
);
	import nntt_pkg::*;

	// Configuration registers, always writable.
	logic [CfgW-1:0] match_dist_q, expiry_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_dist_q <= 16'd200;
			expiry_q <= 16'd1000;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MATCH_DIST: match_dist_q <= cfg.data;
				REG_EXPIRY: expiry_q <= cfg.data;
				default: ;
			endcase
		end
	end

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign in.ready = in_ready;

	// The controller sequences each beat; the datapath holds the table.
	nntt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in.valid && in_ready), .out_ready(out.ready),
		.in_ready(in_ready), .out_valid(out.valid), .cmd(cmd), .sts(sts)
	);

	nntt_datapath #(.MAX_TRACKS(MAX_TRACKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_action(in.action), .in_time(in.time_ms),
		.in_cx(in.centroid_x), .in_cy(in.centroid_y), .in_cz(in.centroid_z),
		.match_dist(match_dist_q), .expiry(expiry_q),
		.o_outcome(out.outcome), .o_id(out.track_id),
		.o_vx(out.vel_x), .o_vy(out.vel_y), .o_vz(out.vel_z),
		.o_removed(out.removed_count), .o_live(out.live_count)
	);

`ifndef SYNTH
	// A result beat is never shown while an input beat can be taken.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in.ready && out.valid)) else $error("ready and valid overlap");
	// Acceptance always leads into processing, never straight to a result.
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(in.valid && in.ready) |=> !out.valid) else $error("result too early");
	// The divider only finishes while a division is awaited.
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> !in.ready) else $error("stray divider result");
`endif
endmodule

>>> tb/tb_nearest_neighbour_track_table.sv
`timescale 1ns / 100ps
// Testbench for the nearest-neighbour track table.
// Depends on nntt_pkg, the channel interfaces in nntt_if.sv and the top level.
module tb_nearest_neighbour_track_table;
	import nntt_pkg::*;

	localparam int NumSlots = 32;
	localparam int StallLimit = 20000;
	localparam logic ActCluster = 1'b0;
	localparam logic ActSweep = 1'b1;

	typedef struct {
		logic action;
		logic [31:0] time_ms;
		logic signed [19:0] cx, cy, cz;
	} obs_t;

	typedef struct {
		outcome_t outcome;
		logic [31:0] track_id;
		logic signed [23:0] vx, vy, vz;
		logic [5:0] removed;
		logic [5:0] live;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nntt_in_if in_ch ();
	nntt_out_if out_ch ();
	nntt_cfg_if cfg_ch ();

	nearest_neighbour_track_table #(.MAX_TRACKS(NumSlots)) u_dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source), .cfg(cfg_ch.sink)
	);

	always #5 clk = ~clk;

	// Shadow copy of the track table, kept in creation order so that slot 0
	// is always the oldest live track.
	logic [15:0] shadow_match_dist = 16'd200;
	logic [15:0] shadow_expiry = 16'd1000;
	int unsigned shadow_live = 0;
	logic [31:0] shadow_next_id = 0;
	logic [31:0] shadow_id [NumSlots];
	logic signed [19:0] shadow_pos [NumSlots][3];
	logic signed [23:0] shadow_vel [NumSlots][3];
	logic [31:0] shadow_seen [NumSlots];

	obs_t pending_obs [$];
	report_t expected_reports [$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 1'b0;
	bit in_taken = 1'b0;
	int quiet_cycles = 0;

	// Velocity over one axis: the change times 1000 over the elapsed time,
	// truncated toward zero and clamped to 24 bits.
	function automatic logic signed [23:0] axis_speed(logic signed [19:0] from,
			logic signed [19:0] to, logic [31:0] dt);
		longint q;
		q = (longint'(to) - longint'(from)) * 1000 / longint'({32'd0, dt});
		if (q > 8388607) q = 8388607;
		if (q < -8388608) q = -8388608;
		return q[23:0];
	endfunction

	// Advances the shadow table by one beat and returns the report it causes.
	function automatic report_t track_update(obs_t o);
		report_t r;
		int w, found, s;
		longint unsigned best, d2;
		longint d;
		logic signed [19:0] c [3];
		logic [31:0] dt;
		r = '{OUT_SWEPT, 32'd0, 24'sd0, 24'sd0, 24'sd0, 6'd0, 6'd0};
		c[0] = o.cx; c[1] = o.cy; c[2] = o.cz;
		if (o.action == ActSweep) begin
			w = 0;
			for (int i = 0; i < shadow_live; i++) begin
				if (32'(o.time_ms - shadow_seen[i]) > {16'd0, shadow_expiry}) begin
					r.removed++;
				end else begin
					shadow_id[w] = shadow_id[i];
					shadow_pos[w] = shadow_pos[i];
					shadow_vel[w] = shadow_vel[i];
					shadow_seen[w] = shadow_seen[i];
					w++;
				end
			end
			shadow_live = w;
		end else begin
			best = longint'(shadow_match_dist) * longint'(shadow_match_dist);
			found = -1;
			for (int i = 0; i < shadow_live; i++) begin
				d2 = 0;
				for (int k = 0; k < 3; k++) begin
					d = longint'(c[k]) - longint'(shadow_pos[i][k]);
					d2 += d * d;
				end
				if (d2 < best) begin
					best = d2;
					found = i;
				end
			end
			if (found >= 0) begin
				s = found;
				dt = o.time_ms - shadow_seen[s];
				for (int k = 0; k < 3; k++) begin
					// With no time elapsed the old velocity stands.
					if (dt != 0) shadow_vel[s][k] = axis_speed(shadow_pos[s][k], c[k], dt);
					shadow_pos[s][k] = c[k];
				end
				shadow_seen[s] = o.time_ms;
				r.outcome = OUT_UPDATED;
				r.track_id = shadow_id[s];
				r.vx = shadow_vel[s][0]; r.vy = shadow_vel[s][1]; r.vz = shadow_vel[s][2];
			end else if (shadow_live < NumSlots) begin
				shadow_id[shadow_live] = shadow_next_id;
				for (int k = 0; k < 3; k++) begin
					shadow_pos[shadow_live][k] = c[k];
					shadow_vel[shadow_live][k] = 24'sd0;
				end
				shadow_seen[shadow_live] = o.time_ms;
				r.outcome = OUT_CREATED;
				r.track_id = shadow_next_id;
				shadow_next_id++;
				shadow_live++;
			end else begin
				r.outcome = OUT_DROPPED;
			end
		end
		r.live = 6'(shadow_live);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// The driver sees acceptance late through in_taken, which
	// the monitor samples at the rising edge, so a beat accepted there is still
	// at the front of the queue when it is popped.
	// Driver: offers the oldest pending beat, idling at random.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				expected_reports.push_back(track_update(pending_obs.pop_front()));
			end
			if (pending_obs.size() != 0 && ($urandom_range(99) >= send_idle_pct
					|| (in_ch.valid && !in_taken))) begin
				in_ch.valid <= 1'b1;
				in_ch.action <= pending_obs[0].action;
				in_ch.time_ms <= pending_obs[0].time_ms;
				in_ch.centroid_x <= pending_obs[0].cx;
				in_ch.centroid_y <= pending_obs[0].cy;
				in_ch.centroid_z <= pending_obs[0].cz;
			end else begin
				in_ch.valid <= 1'b0;
			end
			out_ch.ready <= !recv_hold && $urandom_range(99) >= recv_idle_pct;
		end
	end

	// Monitor: compares each result beat with the oldest expectation.
	always @(posedge clk) begin
		report_t e;
		in_taken <= arst_n && in_ch.valid && in_ch.ready;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("unexpected beat", 32'(out_ch.outcome), 32'd0);
				end else begin
					e = expected_reports.pop_front();
					if (out_ch.outcome !== e.outcome)
						report_mismatch("outcome", 32'(out_ch.outcome), 32'(e.outcome));
					if (out_ch.track_id !== e.track_id)
						report_mismatch("track_id", out_ch.track_id, e.track_id);
					if (out_ch.vel_x !== e.vx)
						report_mismatch("vel_x", 32'(out_ch.vel_x), 32'(e.vx));
					if (out_ch.vel_y !== e.vy)
						report_mismatch("vel_y", 32'(out_ch.vel_y), 32'(e.vy));
					if (out_ch.vel_z !== e.vz)
						report_mismatch("vel_z", 32'(out_ch.vel_z), 32'(e.vz));
					if (out_ch.removed_count !== e.removed)
						report_mismatch("removed_count", 32'(out_ch.removed_count),
							32'(e.removed));
					if (out_ch.live_count !== e.live)
						report_mismatch("live_count", 32'(out_ch.live_count), 32'(e.live));
				end
			end
			// Watchdog: an accepted beat on any channel, or recv_hold, counts as progress.
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready) || recv_hold)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > StallLimit) begin
				$display("nearest_neighbour_track_table test failed");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_obs.size() != 0 || in_ch.valid || expected_reports.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_MATCH_DIST) shadow_match_dist = value;
		else shadow_expiry = value;
	endtask

	function automatic obs_t make_obs(logic act, logic [31:0] t, logic signed [19:0] x,
			logic signed [19:0] y, logic signed [19:0] z);
		obs_t o;
		o.action = act; o.time_ms = t; o.cx = x; o.cy = y; o.cz = z;
		return o;
	endfunction

	// Random traffic: a handful of objects drifting around a few centres, with
	// time mostly advancing by small steps, plus occasional sweeps and noise beats.
	task automatic random_phase(int count, int spread, int step);
		logic [31:0] now;
		logic signed [19:0] base [8][3];
		int j;
		now = $urandom;
		for (int b = 0; b < 8; b++)
			for (int k = 0; k < 3; k++) base[b][k] = 20'($urandom);
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(19))
				0: now = $urandom;
				1, 2: ;
				default: now += $urandom_range(step);
			endcase
			if ($urandom_range(9) == 0) begin
				pending_obs.push_back(make_obs(ActSweep, now, 20'($urandom), 20'($urandom),
					20'($urandom)));
			end else if ($urandom_range(9) == 0) begin
				pending_obs.push_back(make_obs(ActCluster, now, 20'($urandom), 20'($urandom),
					20'($urandom)));
			end else begin
				j = $urandom_range(7);
				for (int k = 0; k < 3; k++)
					base[j][k] += 20'(int'($urandom_range(2 * spread)) - spread);
				pending_obs.push_back(make_obs(ActCluster, now, base[j][0], base[j][1],
					base[j][2]));
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = 1'b0;
		in_ch.time_ms = '0;
		in_ch.centroid_x = '0;
		in_ch.centroid_y = '0;
		in_ch.centroid_z = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MATCH_DIST;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset settings: create, match with no time
		// elapsed, time running backwards, field extremes, filling the table
		// until beats are dropped, and sweeps.
		pending_obs.push_back(make_obs(ActCluster, 32'd0, 20'sd0, 20'sd0, 20'sd0));
		pending_obs.push_back(make_obs(ActCluster, 32'd0, 20'sd10, -20'sd10, 20'sd5));
		pending_obs.push_back(make_obs(ActCluster, 32'd1, 20'sd150, 20'sd0, 20'sd0));
		pending_obs.push_back(make_obs(ActCluster, 32'd2, 20'sd300, 20'sd0, 20'sd0));
		pending_obs.push_back(make_obs(ActCluster, 32'd3, 20'sd150, 20'sd0, 20'sd0));
		pending_obs.push_back(make_obs(ActCluster, 32'd2, 20'sd140, 20'sd0, 20'sd0));
		pending_obs.push_back(make_obs(ActCluster, 32'd100, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
		pending_obs.push_back(make_obs(ActCluster, 32'd100, 20'h80000, 20'h80000, 20'h80000));
		pending_obs.push_back(make_obs(ActCluster, 32'hFFFFFFFF, 20'h7FFF0, 20'h7FFFF,
			20'h7FFF0));
		pending_obs.push_back(make_obs(ActSweep, 32'd1100, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
		pending_obs.push_back(make_obs(ActSweep, 32'hFFFFFFFF, 20'h0, 20'h0, 20'h0));
		for (int i = 0; i < 34; i++)
			pending_obs.push_back(make_obs(ActCluster, 32'd5000, 20'(i * 1000), 20'sd0, 20'sd0));
		pending_obs.push_back(make_obs(ActSweep, 32'd5000, 20'h0, 20'h0, 20'h0));
		wait_drained();

		// Sender idles more lightly than the receiver; the receiver then holds
		// off for a long stretch so that the block backs up into its input.
		send_idle_pct = 15;
		recv_idle_pct = 56;
		write_reg(REG_MATCH_DIST, 16'd65535);
		write_reg(REG_EXPIRY, 16'd0);
		random_phase(400, 20000, 20);
		recv_hold = 1'b1;
		repeat (3000) @(negedge clk);
		recv_hold = 1'b0;
		wait_drained();

		send_idle_pct = 56;
		recv_idle_pct = 15;
		write_reg(REG_MATCH_DIST, 16'd0);
		write_reg(REG_EXPIRY, 16'd65535);
		random_phase(300, 500, 3000);
		wait_drained();
		write_reg(REG_MATCH_DIST, 16'd300);
		write_reg(REG_EXPIRY, 16'd500);
		random_phase(600, 200, 200);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_MATCH_DIST, 16'd5000);
		write_reg(REG_EXPIRY, 16'd60000);
		random_phase(700, 3000, 2000);
		wait_drained();

		if (error_count == 0) begin
			$display("nearest_neighbour_track_table test passed");
		end else begin
			$display("nearest_neighbour_track_table test failed");
		end
		$finish;
	end
endmodule
